@@ rtl/ray_aabb_slab_test_assert.svh @@
// assertion helpers shared by the ray/box slab test rtl
`ifndef RAY_AABB_SLAB_TEST_ASSERT_SVH
`define RAY_AABB_SLAB_TEST_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rat assertion failed");

// next-cycle implication, checked outside reset
`define RAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rat assertion failed");

`endif

@@ rtl/rat_pkg.sv @@
// ----------------------------------------------------------------------------
// rat_pkg
// shared widths, latencies and saturation helpers of the ray/box slab test
// ----------------------------------------------------------------------------
package rat_pkg;

    localparam int W          = 32;
    localparam int FRAC       = 16;
    localparam int NUM_W      = W + 1 + FRAC;     // magnitude of (bound - origin) << 16
    localparam int DIV_STAGES = NUM_W;            // one quotient bit per stage
    localparam int PIPE_LAT   = DIV_STAGES + 5;   // start edge to o_valid sample edge
    localparam int SUM_W      = W + 1 + FRAC + 1; // origin + (dir * t >>> 16)

    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

    // signed value of SUM_W bits clamped to W bits
    function automatic logic signed [W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(S_MAX);
        lo = SUM_W'(S_MIN);
        if (v > hi) begin
            return S_MAX;
        end else if (v < lo) begin
            return S_MIN;
        end
        return v[W-1:0];
    endfunction

    // sign and quotient magnitude to a clamped signed W-bit value
    function automatic logic signed [W-1:0] sat_quot(input logic neg,
                                                     input logic [NUM_W-1:0] mag);
        logic [NUM_W-1:0] lim;
        lim = NUM_W'(1) << (W - 1);
        if (neg) begin
            if (mag > lim) begin
                return S_MIN;
            end
            return -$signed(mag[W-1:0]);
        end
        if (mag >= lim) begin
            return S_MAX;
        end
        return $signed(mag[W-1:0]);
    endfunction

endpackage

@@ rtl/ray_aabb_slab_test.sv @@
// ----------------------------------------------------------------------------
// ray_aabb_slab_test
// ray versus axis-aligned box, slab method, signed Q16.16, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   command channel: present a ray (origin, direction) and a box (min and max
//   corners) on the i_ ports and raise start; the transfer happens at the
//   clock edge where start is high and busy is low. busy is always low, so a
//   new test can be issued every cycle.
//   result channel: o_valid is high for exactly one cycle per test, with
//   o_hit, o_entry_t and the entry point o_entry_x/y/z; on a miss all result
//   fields read zero. results leave in issue order.
// pipeline and throughput
//   the path from the start transfer to the o_valid cycle runs through one
//   input register, 49 divider stages (one quotient bit each, six dividers
//   side by side for both slab planes of three axes), slab pair ordering,
//   interval intersection, the dir * t multiply and the final add/saturate.
//   throughput is one test per cycle.
// reset
//   i_rst_n is synchronous, active low; it drops every test in flight.
// stall
//   the receiver has no way to hold results off, so nothing stalls.
// ----------------------------------------------------------------------------
`include "ray_aabb_slab_test_assert.svh"

module ray_aabb_slab_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [rat_pkg::W-1:0]  i_origin_x,
    input  logic signed [rat_pkg::W-1:0]  i_origin_y,
    input  logic signed [rat_pkg::W-1:0]  i_origin_z,
    input  logic signed [rat_pkg::W-1:0]  i_dir_x,
    input  logic signed [rat_pkg::W-1:0]  i_dir_y,
    input  logic signed [rat_pkg::W-1:0]  i_dir_z,
    input  logic signed [rat_pkg::W-1:0]  i_box_min_x,
    input  logic signed [rat_pkg::W-1:0]  i_box_min_y,
    input  logic signed [rat_pkg::W-1:0]  i_box_min_z,
    input  logic signed [rat_pkg::W-1:0]  i_box_max_x,
    input  logic signed [rat_pkg::W-1:0]  i_box_max_y,
    input  logic signed [rat_pkg::W-1:0]  i_box_max_z,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [rat_pkg::W-2:0]         o_entry_t,
    output logic signed [rat_pkg::W-1:0]  o_entry_x,
    output logic signed [rat_pkg::W-1:0]  o_entry_y,
    output logic signed [rat_pkg::W-1:0]  o_entry_z
);

    localparam int W = rat_pkg::W;

    // side data that travels next to the divider pipeline
    typedef struct packed {
        logic [2:0][W-1:0] org;
        logic [2:0][W-1:0] dir;
        logic              pmiss;   // origin outside a parallel slab
    } t_side;

    // never backs up
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic              r_s1_vld;
    logic [2:0][W-1:0] r_s1_org;
    logic [2:0][W-1:0] r_s1_dir;
    logic [2:0][W-1:0] r_s1_lo;
    logic [2:0][W-1:0] r_s1_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
        r_s1_org <= {i_origin_z, i_origin_y, i_origin_x};
        r_s1_dir <= {i_dir_z, i_dir_y, i_dir_x};
        r_s1_lo  <= {i_box_min_z, i_box_min_y, i_box_min_x};
        r_s1_hi  <= {i_box_max_z, i_box_max_y, i_box_max_x};
    end

    // ------------------------------------------------------------------
    // divider feed: |bound - origin| << 16 over |dir|, sign on the side
    // ------------------------------------------------------------------
    logic [2:0]              div_vld_lo;
    logic [2:0]              div_vld_hi;
    logic signed [W-1:0]     q_lo [3];
    logic signed [W-1:0]     q_hi [3];
    logic [2:0]              par_out;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [W:0]          d_lo;
        logic signed [W:0]          d_hi;
        logic [W:0]                 m_lo;
        logic [W:0]                 m_hi;
        logic [W-1:0]               m_dir;
        logic                       s_dir;

        always_comb begin
            d_lo  = $signed({r_s1_lo[a][W-1], r_s1_lo[a]})
                  - $signed({r_s1_org[a][W-1], r_s1_org[a]});
            d_hi  = $signed({r_s1_hi[a][W-1], r_s1_hi[a]})
                  - $signed({r_s1_org[a][W-1], r_s1_org[a]});
            m_lo  = d_lo[W] ? (W+1)'(-d_lo) : d_lo;
            m_hi  = d_hi[W] ? (W+1)'(-d_hi) : d_hi;
            s_dir = r_s1_dir[a][W-1];
            m_dir = s_dir ? W'(-r_s1_dir[a]) : r_s1_dir[a];
        end

        rat_div u_div_lo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_s1_vld),
            .i_num   ({m_lo, {rat_pkg::FRAC{1'b0}}}),
            .i_den   (m_dir),
            .i_neg   (d_lo[W] ^ s_dir),
            .o_valid (div_vld_lo[a]),
            .o_quot  (q_lo[a])
        );

        rat_div u_div_hi (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_s1_vld),
            .i_num   ({m_hi, {rat_pkg::FRAC{1'b0}}}),
            .i_den   (m_dir),
            .i_neg   (d_hi[W] ^ s_dir),
            .o_valid (div_vld_hi[a]),
            .o_quot  (q_hi[a])
        );
    end

    // parallel slab check at the front, result rides the side line
    logic s1_pmiss;
    always_comb begin
        s1_pmiss = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (r_s1_dir[a] == '0 &&
                ($signed(r_s1_org[a]) < $signed(r_s1_lo[a]) ||
                 $signed(r_s1_org[a]) > $signed(r_s1_hi[a]))) begin
                s1_pmiss = 1'b1;
            end
        end
    end

    t_side r_dly [rat_pkg::DIV_STAGES];

    for (genvar i = 0; i < rat_pkg::DIV_STAGES; i++) begin : g_dly
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_dly[i] <= '{org: r_s1_org, dir: r_s1_dir, pmiss: s1_pmiss};
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    t_side side_out;
    assign side_out = r_dly[rat_pkg::DIV_STAGES-1];

    // ------------------------------------------------------------------
    // stage a: order the two slab parameters of each axis
    // ------------------------------------------------------------------
    logic                r_a_vld;
    logic signed [W-1:0] r_a_t1 [3];
    logic signed [W-1:0] r_a_t2 [3];
    logic [2:0]          r_a_par;
    t_side               r_a_side;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            par_out[a] = (side_out.dir[a] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= &{div_vld_lo, div_vld_hi};
        end
        for (int a = 0; a < 3; a++) begin
            r_a_t1[a] <= (q_lo[a] > q_hi[a]) ? q_hi[a] : q_lo[a];
            r_a_t2[a] <= (q_lo[a] > q_hi[a]) ? q_lo[a] : q_hi[a];
        end
        r_a_par  <= par_out;
        r_a_side <= side_out;
    end

    // ------------------------------------------------------------------
    // stage b: intersect the slab intervals
    // ------------------------------------------------------------------
    logic signed [W-1:0] b_tmin;
    logic signed [W-1:0] b_tmax;

    always_comb begin
        b_tmin = '0;
        b_tmax = rat_pkg::S_MAX;
        for (int a = 0; a < 3; a++) begin
            if (!r_a_par[a]) begin
                if (r_a_t1[a] > b_tmin) begin
                    b_tmin = r_a_t1[a];
                end
                if (r_a_t2[a] < b_tmax) begin
                    b_tmax = r_a_t2[a];
                end
            end
        end
    end

    logic                r_b_vld;
    logic                r_b_hit;
    logic signed [W-1:0] r_b_tmin;
    logic signed [W-1:0] r_b_tmax;
    t_side               r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_hit  <= !r_a_side.pmiss && (b_tmin <= b_tmax);
        r_b_tmin <= b_tmin;
        r_b_tmax <= b_tmax;
        r_b_side <= r_a_side;
    end

    // ------------------------------------------------------------------
    // stage c: dir * t
    // ------------------------------------------------------------------
    logic                  r_c_vld;
    logic                  r_c_hit;
    logic [W-2:0]          r_c_t;
    logic signed [2*W-1:0] r_c_prod [3];
    logic [2:0][W-1:0]     r_c_org;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_hit <= r_b_hit;
        r_c_t   <= r_b_tmin[W-2:0];
        for (int a = 0; a < 3; a++) begin
            r_c_prod[a] <= $signed(r_b_side.dir[a]) * $signed(r_b_tmin);
        end
        r_c_org <= r_b_side.org;
    end

    // ------------------------------------------------------------------
    // stage d: origin + floor(dir * t / 2^16), saturate, zero on miss
    // ------------------------------------------------------------------
    logic signed [rat_pkg::SUM_W-1:0] d_sum [3];
    logic signed [W-1:0]              d_pt  [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            d_sum[a] = rat_pkg::SUM_W'($signed(r_c_org[a]))
                     + rat_pkg::SUM_W'(r_c_prod[a] >>> rat_pkg::FRAC);
            d_pt[a]  = rat_pkg::sat_sum(d_sum[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_c_vld;
        end
        o_hit     <= r_c_hit;
        o_entry_t <= r_c_hit ? r_c_t : '0;
        o_entry_x <= r_c_hit ? d_pt[0] : '0;
        o_entry_y <= r_c_hit ? d_pt[1] : '0;
        o_entry_z <= r_c_hit ? d_pt[2] : '0;
    end

    // each result strobe is preceded by a matching start transfer
    `RAT_ASSERT_IMP(a_lat, i_clk, i_rst_n, o_valid, $past(start, rat_pkg::PIPE_LAT))
    // a miss carries all-zero fields
    `RAT_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && !o_hit,
        o_entry_t == '0 && o_entry_x == '0 && o_entry_y == '0 && o_entry_z == '0)
    // a hit leaves a non-empty interval
    `RAT_ASSERT_IMP(a_interval, i_clk, i_rst_n, r_b_vld && r_b_hit, r_b_tmin <= r_b_tmax)
    // entry parameter is never negative
    `RAT_ASSERT_NXT(a_tmin_pos, i_clk, i_rst_n, r_a_vld, r_b_tmin >= 0)

endmodule

@@ rtl/rat_div.sv @@
// ----------------------------------------------------------------------------
// rat_div
// pipelined restoring divider, one quotient bit per stage, saturated output
// ----------------------------------------------------------------------------
`include "ray_aabb_slab_test_assert.svh"

module rat_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [rat_pkg::NUM_W-1:0]     i_num,
    input  logic [rat_pkg::W-1:0]         i_den,
    input  logic                          i_neg,
    output logic                          o_valid,
    output logic signed [rat_pkg::W-1:0]  o_quot
);

    logic                      r_vld [rat_pkg::DIV_STAGES];
    logic                      r_neg [rat_pkg::DIV_STAGES];
    logic [rat_pkg::W-1:0]     r_den [rat_pkg::DIV_STAGES];
    logic [rat_pkg::W-1:0]     r_rem [rat_pkg::DIV_STAGES];
    logic [rat_pkg::NUM_W-1:0] r_num [rat_pkg::DIV_STAGES];
    logic [rat_pkg::NUM_W-1:0] r_q   [rat_pkg::DIV_STAGES];

    for (genvar i = 0; i < rat_pkg::DIV_STAGES; i++) begin : g_stage
        logic                      p_vld;
        logic                      p_neg;
        logic [rat_pkg::W-1:0]     p_den;
        logic [rat_pkg::W-1:0]     p_rem;
        logic [rat_pkg::NUM_W-1:0] p_num;
        logic [rat_pkg::NUM_W-1:0] p_q;
        logic [rat_pkg::W:0]       tst;
        logic                      ge;
        logic [rat_pkg::W-1:0]     n_rem;

        if (i == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_neg = i_neg;
            assign p_den = i_den;
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_q   = '0;
        end else begin : g_next
            assign p_vld = r_vld[i-1];
            assign p_neg = r_neg[i-1];
            assign p_den = r_den[i-1];
            assign p_rem = r_rem[i-1];
            assign p_num = r_num[i-1];
            assign p_q   = r_q[i-1];
        end

        // shift in next numerator bit, subtract divisor if it fits
        always_comb begin
            tst   = {p_rem, p_num[rat_pkg::NUM_W-1]};
            ge    = (tst >= {1'b0, p_den});
            n_rem = ge ? rat_pkg::W'(tst - {1'b0, p_den}) : tst[rat_pkg::W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= p_vld;
            end
            r_neg[i] <= p_neg;
            r_den[i] <= p_den;
            r_rem[i] <= n_rem;
            r_num[i] <= {p_num[rat_pkg::NUM_W-2:0], 1'b0};
            r_q[i]   <= {p_q[rat_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_valid = r_vld[rat_pkg::DIV_STAGES-1];
    assign o_quot  = rat_pkg::sat_quot(r_neg[rat_pkg::DIV_STAGES-1],
                                       r_q[rat_pkg::DIV_STAGES-1]);

    `RAT_ASSERT_IMP(a_div_lat, i_clk, i_rst_n, o_valid, $past(i_valid, rat_pkg::DIV_STAGES))
    `RAT_ASSERT_IMP(a_div_rem, i_clk, i_rst_n,
        o_valid && (r_den[rat_pkg::DIV_STAGES-1] != '0),
        r_rem[rat_pkg::DIV_STAGES-1] < r_den[rat_pkg::DIV_STAGES-1])

endmodule
